// ----- rtl/mrrwa_pkg.sv -----
// ============================================================================
// mrrwa_pkg: shared types and constants for the ring write admission unit
// Item layouts, register indexes, request codes and parameter defaults.
// ============================================================================
`default_nettype none

package mrrwa_pkg;

    // Parameter defaults
    localparam int MAX_READERS_DEF    = 16;
    localparam int GRANULE_DEF        = 8;
    localparam int RING_ADDR_BITS_DEF = 16;

    // Smallest ring the unit works with
    localparam int RING_MIN = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_READERS = 1'd1;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TAIL  = 1'b1;

    // Largest value of a 17-bit result field
    localparam logic [16:0] F17_MAX = 17'h1FFFF;

    // Input item
    typedef struct packed {
        logic        req_type;
        logic [16:0] msg_size;
        logic [3:0]  reader_index;
        logic [15:0] reader_tail;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic        accepted;
        logic [15:0] write_offset;
        logic [16:0] first_part_len;
        logic [16:0] padded_size;
        logic [16:0] free_bytes;
        logic [31:0] msg_seq;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/mrrwa_rem_unit.sv -----
// ============================================================================
// mrrwa_rem_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder only.
// ============================================================================
`default_nettype none

module mrrwa_rem_unit #(
    parameter int DVW = 17,
    parameter int DSW = 17
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DVW-1:0] i_dividend,
    input  wire logic [DSW-1:0] i_divisor,
    output logic                o_done,
    output logic [DSW-1:0]      o_rem
);

    localparam int CNTW = $clog2(DVW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DSW-1:0]  r_rem;
    logic [DVW-1:0]  r_dvd;
    logic [DSW-1:0]  r_dsr;

    logic [DSW:0]    n_trial;
    logic [DSW-1:0]  n_rem;

    // Shift in the next dividend bit and subtract the divisor if it fits
    always_comb begin
        n_trial = {r_rem, r_dvd[DVW-1]};
        if (n_trial >= {1'b0, r_dsr}) begin
            n_rem = DSW'(n_trial - {1'b0, r_dsr});
        end else begin
            n_rem = n_trial[DSW-1:0];
        end
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DVW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DVW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- rtl/multi_reader_ring_write_admission_unit.sv -----
// ============================================================================
// multi_reader_ring_write_admission_unit: ring buffer write admission
// Pads write sizes to the granule, finds the free space from the reader
// tails kept in a small memory, admits or refuses the write, advances the
// head and counts messages. Tail updates store one reader's tail.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   in      | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//   out     | out       | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//   cfg     | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One item is processed at a time. A tail update's result is set when the
// item is taken and is loaded once the output register is free. A write's
// result is loaded after the tail scan (one memory read per active reader,
// then read, distance and minimum stages) and the decision; a head beyond
// a shrunk ring first passes through the remainder unit, and a granule that
// is not a power of two adds a remainder step before the scan.
// Reset is synchronous; the tail memory reads as zero through per-entry
// valid bits, so no clearing pass is needed. A stalled result sits in the
// output register; the next item is taken once the result has moved there.
// ============================================================================
`default_nettype none

module multi_reader_ring_write_admission_unit
    import mrrwa_pkg::*;
#(
    parameter int MAX_READERS    = MAX_READERS_DEF,
    parameter int GRANULE        = GRANULE_DEF,
    parameter int RING_ADDR_BITS = RING_ADDR_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Widths
    localparam int HW       = RING_ADDR_BITS;
    localparam int RW       = HW + 1;
    localparam int RING_MAX = 1 << HW;
    localparam int RING_MAX_RESET = 65536;
    localparam int AW       = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int CW       = $clog2(MAX_READERS + 1);
    localparam int DW       = ((RW > 16) ? RW : 16) + 1;
    localparam int PW       = 18;
    localparam int SW       = ((PW > RW) ? PW : RW) + 1;
    localparam int DVW      = HW;
    localparam int DSW      = RW;
    localparam bit G_POW2   = (GRANULE & (GRANULE - 1)) == 0;
    localparam logic [15:0] TAIL_MASK =
        (RING_ADDR_BITS >= 16) ? 16'hFFFF : 16'((1 << RING_ADDR_BITS) - 1);

    // Reciprocal of the granule, exact for every 17-bit size
    localparam int          QS = 17 + $clog2(GRANULE);
    localparam logic [17:0] QM = 18'(((1 << QS) + GRANULE - 1) / GRANULE);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HMOD   = 3'd1;
    localparam logic [2:0] S_SIZE   = 3'd2;
    localparam logic [2:0] S_SMOD   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    function automatic logic [16:0] sat17(input logic [31:0] v);
        return (v > 32'(F17_MAX)) ? F17_MAX : v[16:0];
    endfunction

    // Control registers
    logic [2:0]             r_state;
    logic                   r_out_valid;
    logic [16:0]            r_ring_size;
    logic [4:0]             r_num_readers;
    logic [HW-1:0]          r_head;
    logic [31:0]            r_msg_cnt;
    logic [RW-1:0]          r_ring;
    logic [CW-1:0]          r_nrd;
    logic [CW-1:0]          r_issue;
    logic                   r_pend;
    logic                   r_dv;
    logic [MAX_READERS-1:0] r_tail_vld;

    // Payload registers
    t_in_item               r_in;
    t_out_item              r_res;
    t_out_item              r_out;
    logic [PW-1:0]          r_padded;
    logic [16:0]            r_quo;
    logic [RW-1:0]          r_rmh;
    logic [RW-1:0]          r_best;
    logic [RW-1:0]          r_d;
    logic [15:0]            r_rd_data;
    logic                   r_rd_vld;
    logic [15:0]            r_tail_mem [MAX_READERS];

    // Combinational
    logic                   in_acc;
    logic                   idx_ok;
    logic                   tail_we;
    logic [RW-1:0]          ring_eff;
    logic [CW-1:0]          nrd_eff;
    logic                   head_big;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   rem_start;
    logic [DVW-1:0]         rem_dvd;
    logic [DSW-1:0]         rem_dsr;
    logic                   rem_done;
    logic [DSW-1:0]         rem_out;
    logic [34:0]            quo_prod;
    logic [PW-1:0]          size_rem;
    logic [PW-1:0]          n_padded;
    logic [15:0]            tail_val;
    logic [DW-1:0]          d_raw;
    logic [RW-1:0]          n_d;
    logic                   fits;
    logic [SW-1:0]          to_first;
    logic [SW-1:0]          head_sum;
    logic [HW-1:0]          n_head;
    logic                   out_load;
    logic                   scan_end;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_ok     = 32'(i_in_data.reader_index) < 32'(MAX_READERS);
    assign tail_we    = in_acc && (i_in_data.req_type == REQ_TAIL) && idx_ok;

    // Clamp the configured ring size and reader count
    always_comb begin
        if (32'(r_ring_size) < 32'(RING_MIN)) begin
            ring_eff = RW'(RING_MIN);
        end else if (32'(r_ring_size) > 32'(RING_MAX)) begin
            ring_eff = RW'(RING_MAX);
        end else begin
            ring_eff = RW'(r_ring_size);
        end
        if (r_num_readers == 5'd0) begin
            nrd_eff = CW'(1);
        end else if (32'(r_num_readers) > 32'(MAX_READERS)) begin
            nrd_eff = CW'(MAX_READERS);
        end else begin
            nrd_eff = CW'(r_num_readers);
        end
    end

    assign head_big = RW'(r_head) >= ring_eff;

    // Remainder unit: head modulo a shrunk ring
    assign rem_start = in_acc && (i_in_data.req_type == REQ_WRITE) && head_big;
    assign rem_dvd   = r_head;
    assign rem_dsr   = ring_eff;

    mrrwa_rem_unit #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dvd),
        .i_divisor  (rem_dsr),
        .o_done     (rem_done),
        .o_rem      (rem_out)
    );

    // Quotient of the size by the granule through a reciprocal multiply
    assign quo_prod = {18'd0, r_in.msg_size} * {17'd0, QM};

    // Pad the size up to the granule
    always_comb begin
        if (G_POW2) begin
            size_rem = PW'(r_in.msg_size) & PW'(GRANULE - 1);
        end else begin
            size_rem = PW'(r_in.msg_size) - PW'(r_quo) * PW'(GRANULE);
        end
        if (size_rem == '0) begin
            n_padded = PW'(r_in.msg_size);
        end else begin
            n_padded = PW'(r_in.msg_size) + PW'(GRANULE) - size_rem;
        end
    end

    // Tail scan: issue one read per active reader
    assign rd_en    = (r_state == S_SCAN) && (r_issue < r_nrd);
    assign rd_addr  = r_issue[AW-1:0];
    assign scan_end = (r_state == S_SCAN) && !rd_en && !r_pend && !r_dv;

    // Forward distance from head to tail, saturated at the ring size
    always_comb begin
        tail_val = r_rd_vld ? r_rd_data : 16'd0;
        if (DW'(tail_val) > DW'(r_head)) begin
            d_raw = DW'(tail_val) - DW'(r_head);
        end else begin
            d_raw = DW'(tail_val) + DW'(r_rmh);
        end
        if (d_raw > DW'(r_ring)) begin
            n_d = r_ring;
        end else begin
            n_d = RW'(d_raw);
        end
    end

    // Admission decision and new head
    always_comb begin
        fits = (SW'(r_padded) + SW'(GRANULE)) <= SW'(r_best);
        if (SW'(r_padded) < SW'(r_rmh)) begin
            to_first = SW'(r_padded);
        end else begin
            to_first = SW'(r_rmh);
        end
        head_sum = SW'(r_head) + SW'(r_padded);
        if (head_sum >= SW'(r_ring)) begin
            n_head = HW'(head_sum - SW'(r_ring));
        end else begin
            n_head = HW'(head_sum);
        end
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_ring_size   <= 17'(RING_MAX_RESET);
            r_num_readers <= 5'd1;
            r_head        <= '0;
            r_msg_cnt     <= '0;
            r_ring        <= RW'(RING_MAX);
            r_nrd         <= CW'(1);
            r_issue       <= '0;
            r_pend        <= 1'b0;
            r_dv          <= 1'b0;
            r_tail_vld    <= '0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RING_SIZE:   r_ring_size   <= i_cfg_data[16:0];
                    REG_NUM_READERS: r_num_readers <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (tail_we) begin
                r_tail_vld[AW'(i_in_data.reader_index)] <= 1'b1;
            end

            r_pend <= rd_en;
            r_dv   <= r_pend;
            if (rd_en) begin
                r_issue <= r_issue + CW'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.req_type == REQ_TAIL) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ring <= ring_eff;
                            r_nrd  <= nrd_eff;
                            r_state <= head_big ? S_HMOD : S_SIZE;
                        end
                    end
                end
                S_HMOD: begin
                    // Hold the head modulo the new ring
                    if (rem_done) begin
                        r_head  <= HW'(rem_out);
                        r_state <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    r_issue <= '0;
                    r_state <= G_POW2 ? S_SCAN : S_SMOD;
                end
                S_SMOD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_end) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    // Advance the head and count the message on admission
                    if (fits) begin
                        r_head    <= n_head;
                        r_msg_cnt <= r_msg_cnt + 32'd1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload path
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end

        // Tail update result
        if (in_acc && (i_in_data.req_type == REQ_TAIL)) begin
            r_res.accepted       <= idx_ok;
            r_res.write_offset   <= '0;
            r_res.first_part_len <= '0;
            r_res.padded_size    <= '0;
            r_res.free_bytes     <= '0;
            r_res.msg_seq        <= r_msg_cnt;
        end

        if ((r_state == S_SIZE) && G_POW2) begin
            r_padded <= n_padded;
        end
        if (r_state == S_SMOD) begin
            r_padded <= n_padded;
        end

        // Prepare the scan: space to ring end, start from a whole empty ring
        if (r_state == S_SIZE) begin
            r_rmh  <= r_ring - RW'(r_head);
            r_best <= r_ring;
            r_quo  <= 17'(quo_prod >> QS);
        end

        // Distance stage, then minimum stage
        r_d <= n_d;
        if (r_dv && (r_d < r_best)) begin
            r_best <= r_d;
        end

        // Write result
        if (r_state == S_DECIDE) begin
            r_res.accepted       <= fits;
            r_res.write_offset   <= 16'(r_head);
            r_res.first_part_len <= fits ? sat17(32'(to_first)) : 17'd0;
            r_res.padded_size    <= sat17(32'(r_padded));
            r_res.free_bytes     <= sat17(32'(r_best));
            r_res.msg_seq        <= fits ? (r_msg_cnt + 32'd1) : r_msg_cnt;
        end

        if (out_load) begin
            r_out <= r_res;
        end
    end

    // Tail memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tail_we) begin
            r_tail_mem[AW'(i_in_data.reader_index)] <= i_in_data.reader_tail & TAIL_MASK;
        end
        if (rd_en) begin
            r_rd_data <= r_tail_mem[rd_addr];
            r_rd_vld  <= r_tail_vld[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Head stays inside the ring it was last fitted to
    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (RW'(r_head) < r_ring))
        else $error("head offset outside ring");

    // Free space never exceeds the ring size
    a_free_le_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_best <= r_ring))
        else $error("free space beyond ring size");

    // Message count moves only by one, only after a decision
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_msg_cnt != $past(r_msg_cnt)) |->
            (($past(r_state) == S_DECIDE) && (r_msg_cnt == $past(r_msg_cnt) + 32'd1)))
        else $error("message count changed unexpectedly");

endmodule

`default_nettype wire

// ----- dv/mrrwa_checker.sv -----
// ============================================================================
// mrrwa_checker: result checker for the ring write admission unit
// Watches the request, result and register ports, keeps its own copy of the
// head, reader tails, message count and settings, works out the result of
// every accepted request and compares each returned result field by field.
// ============================================================================
module mrrwa_checker
    import mrrwa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_item              i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_item             i_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_MAX = 1 << RING_ADDR_BITS_DEF;

    // Shadow settings and ring state
    logic [16:0] ring_cfg;
    logic [4:0]  readers_cfg;
    logic [15:0] head_q;
    logic [15:0] tail_q [MAX_READERS_DEF];
    logic [31:0] seq_q;

    // Results still owed by the block, oldest first
    t_out_item   owed_results[$];
    int          fails = 0;

    function automatic logic [16:0] clip17(logic [31:0] v);
        return (v > 32'h1FFFF) ? F17_MAX : v[16:0];
    endfunction

    // Work out the result of one request and advance the shadow state
    function automatic t_out_item admit_request(t_in_item rq);
        logic [31:0] ring;
        logic [31:0] hd;
        logic [31:0] padded;
        logic [31:0] room;
        logic [31:0] fwd_dist;
        logic [31:0] tail;
        logic [31:0] to_end;
        int          n;
        t_out_item   res;
        res         = '0;
        res.msg_seq = seq_q;

        // Store a reader tail; nothing else moves
        if (rq.req_type == REQ_TAIL) begin
            if (rq.reader_index < MAX_READERS_DEF) begin
                tail_q[rq.reader_index] = rq.reader_tail;
                res.accepted = 1'b1;
            end
            return res;
        end

        // Clamp the settings into their working range
        ring = 32'(ring_cfg);
        if (ring < RING_MIN) begin
            ring = RING_MIN;
        end else if (ring > RING_MAX) begin
            ring = RING_MAX;
        end
        n = int'(readers_cfg);
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_READERS_DEF) begin
            n = MAX_READERS_DEF;
        end

        // Fold a head left beyond a shrunk ring
        hd = 32'(head_q);
        if (hd >= ring) begin
            hd = hd % ring;
        end

        padded = (32'(rq.msg_size) + GRANULE_DEF - 1) / GRANULE_DEF * GRANULE_DEF;

        // Free space is the shortest forward distance to any active tail
        room = ring;
        for (int i = 0; i < n; i++) begin
            tail     = 32'(tail_q[i]);
            fwd_dist = (tail > hd) ? tail - hd : tail + ring - hd;
            if (fwd_dist > ring) begin
                fwd_dist = ring;
            end
            if (fwd_dist < room) begin
                room = fwd_dist;
            end
        end

        res.write_offset = hd[15:0];
        res.padded_size  = clip17(padded);
        res.free_bytes   = clip17(room);

        // Refuse when the padded size and one spare granule do not fit
        if (padded + GRANULE_DEF > room) begin
            head_q = hd[15:0];
            return res;
        end

        to_end             = ring - hd;
        res.accepted       = 1'b1;
        res.first_part_len = clip17(padded < to_end ? padded : to_end);

        // Advance the head with wrap and count the message
        hd = hd + padded;
        if (hd >= ring) begin
            hd = hd - ring;
        end
        head_q      = hd[15:0];
        seq_q       = seq_q + 32'd1;
        res.msg_seq = seq_q;
        return res;
    endfunction

    task automatic report(string what, t_out_item exp, t_out_item got);
        fails++;
        if (fails <= 10) begin
            $display("%0t %s: exp acc=%0d off=%0d first=%0d pad=%0d free=%0d seq=%0d",
                     $realtime, what, exp.accepted, exp.write_offset,
                     exp.first_part_len, exp.padded_size, exp.free_bytes, exp.msg_seq);
            $display("%0t %s: got acc=%0d off=%0d first=%0d pad=%0d free=%0d seq=%0d",
                     $realtime, what, got.accepted, got.write_offset,
                     got.first_part_len, got.padded_size, got.free_bytes, got.msg_seq);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp;
        logic [5:0] bad;
        if (!i_rst_n) begin
            ring_cfg    = 17'h10000;
            readers_cfg = 5'd1;
            head_q      = '0;
            seq_q       = '0;
            for (int i = 0; i < MAX_READERS_DEF; i++) begin
                tail_q[i] = '0;
            end
            owed_results.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RING_SIZE:   ring_cfg    = i_cfg_data;
                    REG_NUM_READERS: readers_cfg = i_cfg_data[4:0];
                    default: ;
                endcase
            end

            // Compare a returned result with the oldest one owed
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report("result with none owed", '0, i_out_data);
                end else begin
                    exp = owed_results.pop_front();
                    bad = {i_out_data.accepted       !== exp.accepted,
                           i_out_data.write_offset   !== exp.write_offset,
                           i_out_data.first_part_len !== exp.first_part_len,
                           i_out_data.padded_size    !== exp.padded_size,
                           i_out_data.free_bytes     !== exp.free_bytes,
                           i_out_data.msg_seq        !== exp.msg_seq};
                    if (bad != '0) begin
                        report($sformatf("mismatch fields %06b", bad), exp, i_out_data);
                    end
                end
            end

            // Queue the result of each accepted request
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(admit_request(i_in_data));
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fails;
    end

endmodule

// ----- dv/tb.sv -----
// ============================================================================
// tb: top level bench for the ring write admission unit
// Drives a directed pass over the corner cases, then random phases under
// several ring sizes and reader counts, with random gaps on both channels.
// The checker beside the block predicts and compares every result.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrrwa_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_data;
    int                    fail_count;
    int                    pending;

    // Stimulus shaping
    int                    ring_eff    = 65536;
    int                    readers_eff = 1;
    logic [15:0]           last_head   = '0;
    logic                  stall_on    = 1'b0;
    int                    sent_items  = 0;
    int                    hold_cnt    = 0;

    always #4 clk = ~clk;

    multi_reader_ring_write_admission_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    mrrwa_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Hold off the result channel for a random stall after each item
    always @(posedge clk) begin
        int n;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
        end else if (out_ready && out_valid) begin
            n = stall_on ? $urandom_range(0, 19) : 0;
            out_ready <= (n == 0);
            hold_cnt  <= n;
        end else if (!out_ready) begin
            if (hold_cnt <= 1) begin
                out_ready <= 1'b1;
                hold_cnt  <= 0;
            end else begin
                hold_cnt <= hold_cnt - 1;
            end
        end
    end

    // Follow the head from admitted writes so readers can trail it
    always @(posedge clk) begin
        if (out_valid && out_ready && out_data.accepted && out_data.free_bytes != 0) begin
            last_head <= 16'((32'(out_data.write_offset) + 32'(out_data.padded_size))
                             % ring_eff);
        end
    end

    function automatic t_in_item mk_req(logic rt, logic [16:0] size, logic [3:0] idx,
                                        logic [15:0] tail);
        t_in_item r;
        r.req_type     = rt;
        r.msg_size     = size;
        r.reader_index = idx;
        r.reader_tail  = tail;
        return r;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic push_item(t_in_item it);
        int gap;
        gap = stall_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    // Stop sending and wait until every owed result is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_cfg(logic [16:0] ring, logic [4:0] readers);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_RING_SIZE;
        cfg_data <= ring;
        @(posedge clk);
        cfg_idx  <= REG_NUM_READERS;
        cfg_data <= 17'(readers);
        @(posedge clk);
        cfg_we   <= 1'b0;
        ring_eff    = (int'(ring) < RING_MIN) ? RING_MIN
                    : (int'(ring) > 65536) ? 65536 : int'(ring);
        readers_eff = (readers == 0) ? 1
                    : (int'(readers) > MAX_READERS_DEF) ? MAX_READERS_DEF : int'(readers);
    endtask

    // One random step: reader catch-up, single tail move, noise or a write
    task automatic traffic_step();
        int sel;
        int base;
        int lag;
        logic [16:0] size;
        sel  = $urandom_range(0, 99);
        base = int'(last_head) % ring_eff;
        if (sel < 10) begin
            for (int r = 0; r < readers_eff; r++) begin
                lag = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, ring_eff / 4);
                push_item(mk_req(REQ_TAIL, 17'($urandom), 4'(r),
                                 16'((base + ring_eff - lag) % ring_eff)));
            end
        end else if (sel < 18) begin
            lag = $urandom_range(0, ring_eff / 2);
            push_item(mk_req(REQ_TAIL, 17'($urandom), 4'($urandom_range(0, readers_eff - 1)),
                             16'((base + ring_eff - lag) % ring_eff)));
        end else if (sel < 24) begin
            push_item(mk_req(REQ_TAIL, 17'($urandom), 4'($urandom), 16'($urandom)));
        end else if (sel < 30) begin
            push_item(mk_req(REQ_WRITE, 17'($urandom), 4'($urandom), 16'($urandom)));
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                size = 17'($urandom_range(0, ring_eff));
            end else begin
                size = 17'($urandom_range(0, ring_eff / 8));
            end
            push_item(mk_req(REQ_WRITE, size, 4'($urandom), 16'($urandom)));
        end
        if ($urandom_range(0, 39) == 0) begin
            stall_on <= ~stall_on;
        end
    endtask

    task automatic run_phase(logic [16:0] ring, logic [4:0] readers, int count);
        int goal;
        drain();
        stall_on <= 1'($urandom_range(0, 1));
        write_cfg(ring, readers);
        goal = sent_items + count;
        while (sent_items < goal) begin
            traffic_step();
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full ring, one reader: zero, odd and oversize writes, exact fit, wrap
        write_cfg(17'h10000, 5'd1);
        push_item(mk_req(REQ_WRITE, 17'd0, 4'd0, 16'd0));
        push_item(mk_req(REQ_WRITE, 17'd1, 4'd0, 16'd0));
        push_item(mk_req(REQ_WRITE, 17'd7, 4'd0, 16'd0));
        push_item(mk_req(REQ_WRITE, 17'd65536, 4'd0, 16'd0));
        push_item(mk_req(REQ_WRITE, 17'h1FFFF, 4'hF, 16'hFFFF));
        push_item(mk_req(REQ_WRITE, 17'd65512, 4'd0, 16'd0));
        push_item(mk_req(REQ_TAIL, 17'd0, 4'd0, 16'd65528));
        push_item(mk_req(REQ_WRITE, 17'd100, 4'd0, 16'd0));
        push_item(mk_req(REQ_TAIL, 17'h1FFFF, 4'd15, 16'hFFFF));

        // Smallest ring under the head, all readers, tails beyond the ring
        drain();
        write_cfg(17'd64, 5'd16);
        push_item(mk_req(REQ_WRITE, 17'd8, 4'd0, 16'd0));
        push_item(mk_req(REQ_WRITE, 17'd24, 4'd0, 16'd0));

        // Ring and reader count below range
        drain();
        write_cfg(17'd0, 5'd0);
        push_item(mk_req(REQ_WRITE, 17'd56, 4'd0, 16'd0));
        push_item(mk_req(REQ_WRITE, 17'd0, 4'd0, 16'd0));
        push_item(mk_req(REQ_TAIL, 17'd0, 4'd0, 16'd32));
        push_item(mk_req(REQ_WRITE, 17'd57, 4'd0, 16'd0));

        // Ring and reader count above range
        drain();
        write_cfg(17'h1FFFF, 5'h1F);
        push_item(mk_req(REQ_WRITE, 17'd65495, 4'd0, 16'd0));
        push_item(mk_req(REQ_TAIL, 17'd0, 4'd7, 16'h5A5A));
        push_item(mk_req(REQ_WRITE, 17'd3, 4'd0, 16'd0));

        // Random phases over a spread of settings
        run_phase(17'h10000, 5'd1, 190);
        run_phase(17'd64, 5'd16, 190);
        run_phase(17'd512, 5'd3, 190);
        run_phase(17'h1FFFF, 5'h1F, 180);
        run_phase(17'd0, 5'd0, 180);
        run_phase(17'd1003, 5'd5, 180);
        run_phase(17'($urandom_range(8, 1024) * 8), 5'($urandom_range(1, 16)), 190);
        run_phase(17'($urandom), 5'($urandom), 150);
        run_phase(17'h10000, 5'd16, 150);

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mrrwa_pkg.sv
rtl/mrrwa_rem_unit.sv
rtl/multi_reader_ring_write_admission_unit.sv
dv/mrrwa_checker.sv
dv/tb.sv
